### rtl/core/skf_pkg.sv
// skf_pkg: shared types, widths and register map of the scalar Kalman filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package skf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int GAIN_BITS     = 16;
    localparam int R_W           = 24;
    localparam int Q_W           = 16;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_MEAS_NOISE = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_PROC_NOISE = 3'd4;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic [DATA_W-1:0]        cov_t;
    typedef logic [GAIN_BITS-1:0]     gain_t;
    typedef logic [R_W-1:0]           rnoise_t;
    typedef logic [Q_W-1:0]           qnoise_t;

    // finished result offered by the core to the output stage
    typedef struct packed {
        logic    valid;
        sample_t estimate;
        gain_t   gain;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/scalar_kalman_filter.sv
// scalar_kalman_filter: top level with the APB register file and output stage.
// Uses skf_pkg and instantiates skf_core (which holds skf_gain_div).
//
// One-dimensional Kalman filter, unit observation gain. Each measurement item
// (signed Q16.16) yields one result item: the updated estimate and the gain
// K = P/(P+R) (unsigned Q0.16) used for it. Estimate and covariance P are zero
// after reset. Registers: meas_noise R at byte address 0 (24 bits, reset 0.5),
// process_noise Q at byte address 4 (16 bits, reset 0.001); write them only
// while the filter is idle. Sequence: the accepting edge loads the gain divider;
// out_valid rises after the iterations of the restoring gain divider, the step
// taking the gain, both passes of the shared multiplier, the covariance step and
// the handoff to the output register, which waits while that register is full
// and not drained; the next item can be accepted only after the handoff. The
// divider loop takes most of that time. With a zero denominator or a gain of
// one the divider answers at once, on the accepting edge itself.
// in_ready is high only while the core is idle; a finished result sits
// in the output register, so the next item may be accepted while it waits.
`default_nettype none

module scalar_kalman_filter #(
    parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // APB configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [skf_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [skf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [skf_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // measurement channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire skf_pkg::sample_t               measurement,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output skf_pkg::sample_t                    estimate,
    output skf_pkg::gain_t                      gain
);
    import skf_pkg::*;

    // reset values: R = 0.5, Q = 0.001 rounded, in the chosen fraction width
    localparam rnoise_t R_RESET = R_W'(64'd1 << (FRAC_BITS - 1));
    localparam qnoise_t Q_RESET = Q_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

    rnoise_t meas_noise_reg;
    qnoise_t process_noise_reg;
    logic    wr_en;

    logic    out_valid_reg;
    sample_t estimate_reg;
    gain_t   gain_reg;

    logic    core_idle;
    logic    core_start;
    logic    res_ready;
    result_t res;

    // register file: no wait states, write in the access phase
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_noise_reg    <= R_RESET;
            process_noise_reg <= Q_RESET;
        end
        else if (wr_en)
        begin
            case (paddr)
                ADDR_MEAS_NOISE: meas_noise_reg    <= pwdata[R_W-1:0];
                ADDR_PROC_NOISE: process_noise_reg <= pwdata[Q_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_MEAS_NOISE: prdata = {{(APB_DATA_W - R_W){1'b0}}, meas_noise_reg};
            ADDR_PROC_NOISE: prdata = {{(APB_DATA_W - Q_W){1'b0}}, process_noise_reg};
            default:         prdata = '0;
        endcase
    end

    // input handshake: an item enters whenever the sequencer is idle
    assign in_ready   = core_idle;
    assign core_start = in_valid && core_idle;

    skf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (core_start),
        .z         (measurement),
        .r         (meas_noise_reg),
        .q         (process_noise_reg),
        .idle      (core_idle),
        .res       (res),
        .res_ready (res_ready)
    );

    // output register: free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res.valid && res_ready)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            estimate_reg <= res.estimate;
            gain_reg     <= res.gain;
        end
    end

    assign out_valid = out_valid_reg;
    assign estimate  = estimate_reg;
    assign gain      = gain_reg;

endmodule

`default_nettype wire

### rtl/core/skf_gain_div.sv
// skf_gain_div: restoring divider for the gain K = floor(P * 2^16 / (P + R)).
// One quotient bit per cycle; uses skf_pkg.
`default_nettype none

module skf_gain_div (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire skf_pkg::cov_t          num,
    input  wire logic [skf_pkg::DATA_W:0] den,
    output logic                        done,
    output skf_pkg::gain_t              quo
);
    import skf_pkg::*;

    localparam int CNT_W = $clog2(GAIN_BITS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DATA_W:0]     rem_reg, rem_next;
    logic [DATA_W:0]     den_reg, den_next;
    gain_t               quo_reg, quo_next;
    logic [DATA_W+1:0]   trial;
    logic [DATA_W+1:0]   diff;

    assign trial = {rem_reg, 1'b0};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            den_next = den;
            if (den == '0)
            begin
                // zero denominator: gain is zero
                quo_next = '0;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else if ({1'b0, num} == den)
            begin
                // zero noise with nonzero P: gain of one saturates
                quo_next = '1;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                rem_next  = {1'b0, num};
                quo_next  = '0;
                cnt_next  = CNT_W'(GAIN_BITS);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W+1])
            begin
                rem_next = diff[DATA_W:0];
                quo_next = {quo_reg[GAIN_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DATA_W:0];
                quo_next = {quo_reg[GAIN_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

### rtl/core/skf_core.sv
// skf_core: filter state, sequencer and the shared multiplier with rounding.
// Uses skf_pkg and instantiates skf_gain_div.
`default_nettype none

module skf_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire skf_pkg::sample_t z,
    input  wire skf_pkg::rnoise_t r,
    input  wire skf_pkg::qnoise_t q,
    output logic                  idle,
    output skf_pkg::result_t      res,
    input  wire logic             res_ready
);
    import skf_pkg::*;

    localparam int MAG_W  = DATA_W + 1;
    localparam int MB_W   = GAIN_BITS + 1;
    localparam int PROD_W = MAG_W + MB_W;
    localparam int SUM_W  = DATA_W + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MULX = 3'd2;
    localparam logic [2:0] S_MULP = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic [MB_W-1:0]   GAIN_ONE = MB_W'(1) << GAIN_BITS;
    localparam logic [PROD_W-1:0] HALF     = PROD_W'(1) << (GAIN_BITS - 1);
    localparam logic signed [SUM_W-1:0] X_MAX = SUM_W'(32'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] X_MIN = -(SUM_W'(1) << (DATA_W - 1));

    logic [2:0]              state_reg, state_next;
    sample_t                 x_reg;
    cov_t                    p_reg;
    logic signed [MAG_W-1:0] diff_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;
    gain_t                   k_reg;
    logic [PROD_W-1:0]       prod_reg;

    logic [MAG_W-1:0]        mul_a;
    logic [MB_W-1:0]         mul_b;
    logic [PROD_W-1:0]       product;
    logic [PROD_W-1:0]       rnd_sum;
    logic [MAG_W-1:0]        rnd;
    logic signed [SUM_W-1:0] x_sum;
    logic signed [SUM_W-1:0] corr_s;
    sample_t                 x_new;
    logic [SUM_W-1:0]        p_sum;
    cov_t                    p_new;

    logic                    div_start;
    logic                    div_done;
    gain_t                   div_quo;
    logic [DATA_W:0]         den;

    assign div_start = start && (state_reg == S_IDLE);
    assign den       = {1'b0, p_reg} + {{(DATA_W + 1 - R_W){1'b0}}, r};

    skf_gain_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (p_reg),
        .den   (den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // one multiplier: |z - x| * K, then P * (1 - K)
    always_comb
    begin
        if (state_reg == S_MULX)
        begin
            mul_a = mag_reg;
            mul_b = {1'b0, k_reg};
        end
        else
        begin
            mul_a = {1'b0, p_reg};
            mul_b = GAIN_ONE - {1'b0, k_reg};
        end
    end

    assign product = mul_a * mul_b;
    assign rnd_sum = prod_reg + HALF;
    assign rnd     = rnd_sum[GAIN_BITS +: MAG_W];

    // estimate update from the rounded correction, clamped to 32 bits
    always_comb
    begin
        corr_s = neg_reg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
        x_sum  = $signed({{(SUM_W - DATA_W){x_reg[DATA_W-1]}}, x_reg}) + corr_s;
        if (x_sum > X_MAX)
            x_new = X_MAX[DATA_W-1:0];
        else if (x_sum < X_MIN)
            x_new = X_MIN[DATA_W-1:0];
        else
            x_new = x_sum[DATA_W-1:0];
    end

    // covariance plus process noise, saturated
    always_comb
    begin
        p_sum = {1'b0, rnd} + {{(SUM_W - Q_W){1'b0}}, q};
        if (p_sum[SUM_W-1:DATA_W] != '0)
            p_new = '1;
        else
            p_new = p_sum[DATA_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (start) state_next = S_DIV;
            S_DIV:  if (div_done) state_next = S_MULX;
            S_MULX: state_next = S_MULP;
            S_MULP: state_next = S_FIN;
            S_FIN:  state_next = S_DONE;
            S_DONE: if (res_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            x_reg     <= '0;
            p_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_MULP)
                x_reg <= x_new;
            if (state_reg == S_FIN)
                p_reg <= p_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
            diff_reg <= $signed({z[DATA_W-1], z}) - $signed({x_reg[DATA_W-1], x_reg});
        if (state_reg == S_DIV)
        begin
            mag_reg <= diff_reg[MAG_W-1] ? MAG_W'(-diff_reg) : MAG_W'(diff_reg);
            neg_reg <= diff_reg[MAG_W-1];
            if (div_done)
                k_reg <= div_quo;
        end
        if (state_reg == S_MULX || state_reg == S_MULP)
            prod_reg <= product;
    end

    assign idle         = (state_reg == S_IDLE);
    assign res.valid    = (state_reg == S_DONE);
    assign res.estimate = x_reg;
    assign res.gain     = k_reg;

endmodule

`default_nettype wire
